// ----- rtl/core/bpcf_pkg.sv -----
// shared types, constants and pixel filter functions of the bitmap pixel color filter
`timescale 1ns / 1ps

package bpcf_pkg;

    localparam int unsigned MAX_ROW_BYTES = 16384;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned OFFSET_W    = 32;
    localparam int unsigned START_POS_W = 14;
    localparam int unsigned BPP_W       = 3;
    localparam int unsigned ROW_BYTES_W = 15;
    localparam int unsigned PAD_W       = 2;
    localparam int unsigned S_DATA_W    = 24;
    localparam int unsigned M_DATA_W    = 56;

    localparam logic [ROW_BYTES_W-1:0] MAX_ROW_BYTES_V = ROW_BYTES_W'(MAX_ROW_BYTES);

    // reciprocal of three for sums below 1024
    localparam logic [9:0] RECIP3     = 10'd683;
    localparam int unsigned RECIP3_SH = 11;

    typedef enum logic [2:0] {
        MODE_GRAY     = 3'd0,
        MODE_BOOST_0  = 3'd1,
        MODE_BOOST_1  = 3'd2,
        MODE_BOOST_2  = 3'd3,
        MODE_BOOST_02 = 3'd4,
        MODE_TRANS    = 3'd5,
        MODE_NEG      = 3'd6,
        MODE_PASS     = 3'd7
    } filter_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FILTER_MODE    = 3'd0,
        CFG_START_OFFSET   = 3'd1,
        CFG_START_POSITION = 3'd2,
        CFG_BYTES_PER_PIX  = 3'd3,
        CFG_ROW_BYTES      = 3'd4,
        CFG_LINE_PADDING   = 3'd5
    } cfg_index_t;

    function automatic logic [CHAN_W-1:0] boost(input logic [CHAN_W-1:0] x);
        logic [CHAN_W:0] v;
        v = {1'b0, x} + {2'b00, x[CHAN_W-1:1]};
        return v[CHAN_W] ? {CHAN_W{1'b1}} : v[CHAN_W-1:0];
    endfunction

    function automatic logic [CHAN_W-1:0] half(input logic [CHAN_W-1:0] x);
        return {1'b0, x[CHAN_W-1:1]};
    endfunction

    function automatic logic [CHAN_W-1:0] fade(input logic [CHAN_W-1:0] x);
        logic [CHAN_W:0] v;
        v = {1'b0, x} + {1'b0, {CHAN_W{1'b1}}};
        return v[CHAN_W:1];
    endfunction

    function automatic logic [CHAN_W-1:0] gray(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b,
                                               input logic [CHAN_W-1:0] c);
        logic [9:0]  sum;
        logic [19:0] prod;
        sum  = {2'b00, a} + {2'b00, b} + {2'b00, c};
        prod = {10'd0, sum} * {10'd0, RECIP3};
        return prod[RECIP3_SH+CHAN_W-1:RECIP3_SH];
    endfunction

endpackage

// ----- rtl/core/bmp_pixel_color_filter.sv -----
// top level: per pixel color filter and padded row byte offset walk
// the result of an accepted input request is registered and shown on the m_ side in the next cycle
// throughput: one pixel per cycle while not stalled; s_tready follows the output register, m_tready and the divider
// after each configuration write the input stalls while a bit-serial
// divider reduces start_position modulo the line length
// reset: synchronous active-low aresetn restores register defaults and restarts the run
`timescale 1ns / 1ps

module bmp_pixel_color_filter (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [bpcf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bpcf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pixel_in_0, pixel_in_1, pixel_in_2
    input  logic [bpcf_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_out_0, pixel_out_1, pixel_out_2, byte_offset
    output logic [bpcf_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                             m_tlast
);
    import bpcf_pkg::*;

    filter_mode_t           mode_reg;
    logic [OFFSET_W-1:0]    start_offset_reg;
    logic [START_POS_W-1:0] start_pos_reg;
    logic [BPP_W-1:0]       bpp_reg;
    logic [ROW_BYTES_W-1:0] row_bytes_reg;
    logic [PAD_W-1:0]       pad_reg;

    logic [OFFSET_W-1:0]    cur_offset_reg, cur_offset_next;
    logic [ROW_BYTES_W-1:0] row_pos_reg, row_pos_next;
    logic                   at_start_reg;

    logic                   div_load_reg;
    logic [3:0]             div_cnt_reg;
    logic [START_POS_W-1:0] div_dvd_reg;
    logic [ROW_BYTES_W-1:0] div_rem_reg, div_rem_next;
    logic [ROW_BYTES_W:0]   div_shift;
    logic                   div_busy;

    logic                   m_valid_reg;
    logic [CHAN_W-1:0]      m_pix0_reg, m_pix1_reg, m_pix2_reg;
    logic [OFFSET_W-1:0]    m_offset_reg;
    logic                   m_last_reg;

    logic [CHAN_W-1:0]      c0, c1, c2, o0, o1, o2;
    logic [ROW_BYTES_W-1:0] rb, line, pos;
    logic [OFFSET_W-1:0]    off;
    logic [ROW_BYTES_W:0]   pos_step;
    logic                   s_acc;

    assign c0 = s_tdata[CHAN_W-1:0];
    assign c1 = s_tdata[2*CHAN_W-1:CHAN_W];
    assign c2 = s_tdata[3*CHAN_W-1:2*CHAN_W];

    assign rb   = (row_bytes_reg > MAX_ROW_BYTES_V) ? MAX_ROW_BYTES_V : row_bytes_reg;
    assign line = rb + ROW_BYTES_W'(pad_reg);

    // bit-serial restoring division for the start position remainder
    assign div_busy  = div_load_reg || (div_cnt_reg != 4'd0);
    assign div_shift = {div_rem_reg, div_dvd_reg[START_POS_W-1]};
    assign div_rem_next = (div_shift >= {1'b0, line}) ?
                          ROW_BYTES_W'(div_shift - {1'b0, line}) :
                          div_shift[ROW_BYTES_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_load_reg <= 1'b0;
            div_cnt_reg  <= 4'd0;
            div_rem_reg  <= '0;
        end else if (cfg_we) begin
            div_load_reg <= 1'b1;
            div_cnt_reg  <= 4'd0;
        end else if (div_load_reg) begin
            div_load_reg <= 1'b0;
            div_cnt_reg  <= 4'(START_POS_W);
            div_rem_reg  <= '0;
        end else if (div_cnt_reg != 4'd0) begin
            div_cnt_reg  <= div_cnt_reg - 4'd1;
            div_rem_reg  <= div_rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_load_reg) begin
            div_dvd_reg <= start_pos_reg;
        end else if (div_cnt_reg != 4'd0) begin
            div_dvd_reg <= {div_dvd_reg[START_POS_W-2:0], 1'b0};
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_GRAY;
            start_offset_reg <= '0;
            start_pos_reg    <= '0;
            bpp_reg          <= BPP_W'(3);
            row_bytes_reg    <= ROW_BYTES_W'(3);
            pad_reg          <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FILTER_MODE:    mode_reg         <= filter_mode_t'(cfg_wdata[2:0]);
                CFG_START_OFFSET:   start_offset_reg <= cfg_wdata[OFFSET_W-1:0];
                CFG_START_POSITION: start_pos_reg    <= cfg_wdata[START_POS_W-1:0];
                CFG_BYTES_PER_PIX:  bpp_reg          <= cfg_wdata[BPP_W-1:0];
                CFG_ROW_BYTES:      row_bytes_reg    <= cfg_wdata[ROW_BYTES_W-1:0];
                CFG_LINE_PADDING:   pad_reg          <= cfg_wdata[PAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // address walk
    assign pos = at_start_reg ? ((line == '0) ? '0 : div_rem_reg) : row_pos_reg;
    assign off = at_start_reg ? start_offset_reg : cur_offset_reg;
    assign pos_step = {1'b0, pos} + (ROW_BYTES_W+1)'(bpp_reg);

    always_comb begin
        priority if (line == '0) begin
            cur_offset_next = off;
            row_pos_next    = '0;
        end else if (pos_step < {1'b0, rb}) begin
            cur_offset_next = off + OFFSET_W'(bpp_reg);
            row_pos_next    = pos_step[ROW_BYTES_W-1:0];
        end else begin
            // position may lie past a shortened line, so the gap wraps at the offset width
            cur_offset_next = off + OFFSET_W'(line) - OFFSET_W'(pos);
            row_pos_next    = '0;
        end
    end

    // color filter
    always_comb begin
        unique case (mode_reg)
            MODE_GRAY: begin
                o0 = gray(c0, c1, c2);
                o1 = o0;
                o2 = o0;
            end
            MODE_BOOST_0: begin
                o0 = boost(c0); o1 = half(c1); o2 = half(c2);
            end
            MODE_BOOST_1: begin
                o0 = half(c0); o1 = boost(c1); o2 = half(c2);
            end
            MODE_BOOST_2: begin
                o0 = half(c0); o1 = half(c1); o2 = boost(c2);
            end
            MODE_BOOST_02: begin
                o0 = boost(c0); o1 = half(c1); o2 = boost(c2);
            end
            MODE_TRANS: begin
                o0 = fade(c0); o1 = fade(c1); o2 = fade(c2);
            end
            MODE_NEG: begin
                o0 = ~c0; o1 = ~c1; o2 = ~c2;
            end
            MODE_PASS: begin
                o0 = c0; o1 = c1; o2 = c2;
            end
        endcase
    end

    assign s_tready = (!m_valid_reg || m_tready) && !div_busy;
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_offset_reg <= '0;
            row_pos_reg    <= '0;
            at_start_reg   <= 1'b1;
        end else if (s_acc) begin
            cur_offset_reg <= cur_offset_next;
            row_pos_reg    <= row_pos_next;
            at_start_reg   <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_acc) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            m_pix0_reg   <= o0;
            m_pix1_reg   <= o1;
            m_pix2_reg   <= o2;
            m_offset_reg <= off;
            m_last_reg   <= s_tlast;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_offset_reg, m_pix2_reg, m_pix1_reg, m_pix0_reg};
    assign m_tlast  = m_last_reg;

`ifndef ASSERT_OFF
    // no request taken while the start remainder is being recomputed
    assert property (@(posedge aclk) disable iff (!aresetn) div_busy |-> !s_tready)
        else $error("request accepted during start position division");

    // remainder stays below the line length once settled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!div_busy && line != '0) |-> (div_rem_reg < line))
        else $error("start position remainder out of range");

    // a last request restarts the walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tlast) |=> at_start_reg)
        else $error("run did not restart after last request");

    // every accepted request yields a pending result
    assert property (@(posedge aclk) disable iff (!aresetn) s_acc |=> m_valid_reg)
        else $error("result lost after accepted request");

    // a configuration write always starts a new division
    assert property (@(posedge aclk) disable iff (!aresetn) cfg_we |=> div_load_reg)
        else $error("division not restarted after configuration write");
`endif

endmodule
